// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by rre_dp
// no dependencies; every macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked outside reset: the consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rre_pkg.sv =====
// shared types and constants of the rectangle region engine
// no dependencies
package rre_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W   = 2;
    localparam int IN_W    = 16;
    localparam int COORD_W = 17;
    localparam int SIZE_W  = 15;
    localparam int EDGE_W  = 18;
    localparam int ENTRY_W = 2 * COORD_W + 2 * SIZE_W;

    // request command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;

    // piece mask bit positions, in write order
    localparam int PC_KEEP  = 0;
    localparam int PC_ABOVE = 1;
    localparam int PC_BELOW = 2;
    localparam int PC_LEFT  = 3;
    localparam int PC_RIGHT = 4;
    localparam int PC_N     = 5;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic load;
        logic calc;
        logic write_piece;
        logic append;
        logic next_idx;
        logic flip;
        logic ack;
        logic list_item;
    } rre_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_list;
        logic is_add;
        logic is_active;
        logic count_zero;
        logic idx_last;
        logic mask_empty;
        logic out_accept;
    } rre_stat_t;

endpackage

// ===== hw/rtl/rre_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module rre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/rre_ctrl.sv =====
// sequencer of the rectangle region engine
// depends on rre_pkg
module rre_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               command_valid,
    output logic               command_stall,
    input  rre_pkg::rre_stat_t stat,
    output rre_pkg::rre_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_FETCH, S_LOAD, S_CALC, S_PIECE, S_APPEND, S_FLIP, S_RESP
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (command_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.is_list)
                begin
                    if (stat.count_zero)
                    begin
                        cmd.ack    = 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
                else if (stat.is_active)
                begin
                    if (!stat.count_zero)
                        state_next = S_FETCH;
                    else if (stat.is_add)
                        state_next = S_APPEND;
                    else
                        state_next = S_FLIP;
                end
                else
                begin
                    cmd.ack    = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.is_list)
                begin
                    cmd.list_item = 1'b1;
                    state_next    = S_RESP;
                end
                else
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_PIECE;
            end
            S_PIECE:
            begin
                if (!stat.mask_empty)
                begin
                    cmd.write_piece = 1'b1;
                end
                else if (!stat.idx_last)
                begin
                    cmd.next_idx = 1'b1;
                    state_next   = S_FETCH;
                end
                else if (stat.is_add)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    state_next = S_FLIP;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_FLIP;
            end
            S_FLIP:
            begin
                cmd.flip   = 1'b1;
                cmd.ack    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_accept)
                begin
                    if (stat.is_list && !stat.count_zero && !stat.idx_last)
                    begin
                        cmd.next_idx = 1'b1;
                        state_next   = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            command_stall <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            command_stall <= (state_next != S_IDLE);
        end
    end

endmodule

// ===== hw/rtl/rre_dp.sv =====
// datapath of the rectangle region engine: table banks, geometry, result register
// depends on rre_pkg, rre_ram and assert_macros.svh
`include "assert_macros.svh"

module rre_dp #(
    parameter int CAPACITY = rre_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [rre_pkg::CMD_W-1:0]           command,
    input  logic signed [rre_pkg::IN_W-1:0]     pos_x,
    input  logic signed [rre_pkg::IN_W-1:0]     pos_y,
    input  logic signed [rre_pkg::IN_W-1:0]     size_w,
    input  logic signed [rre_pkg::IN_W-1:0]     size_h,
    input  rre_pkg::rre_cmd_t                   cmd,
    output rre_pkg::rre_stat_t                  stat,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [rre_pkg::COORD_W-1:0]  rect_x,
    output logic signed [rre_pkg::COORD_W-1:0]  rect_y,
    output logic [rre_pkg::SIZE_W-1:0]          rect_w,
    output logic [rre_pkg::SIZE_W-1:0]          rect_h,
    output logic                                rect_valid,
    output logic                                last_item,
    output logic                                status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW = rre_pkg::EDGE_W;
    localparam int XW = rre_pkg::COORD_W;
    localparam int SW = rre_pkg::SIZE_W;

    // request registers
    logic [rre_pkg::CMD_W-1:0] kind_reg;
    logic                      active_reg;
    logic signed [EW-1:0]      bx1_reg, bx2_reg, by1_reg, by2_reg;
    logic [SW-1:0]             bw_reg, bh_reg;

    // control registers
    logic [CW-1:0]             count_reg, idx_reg, wcnt_reg;
    logic                      bank_reg, ovf_reg;

    // entry under work and derived edges
    logic signed [XW-1:0]      rx_reg, ry_reg;
    logic [SW-1:0]             rw_reg, rh_reg;
    logic signed [EW-1:0]      rx2_reg, ry2_reg;
    logic signed [EW-1:0]      cx1_reg, cx2_reg, cy1_reg, cy2_reg;
    logic [rre_pkg::PC_N-1:0]  mask_reg;

    // table memory
    logic                      we0, we1;
    logic [rre_pkg::ENTRY_W-1:0] wdata, rdata0, rdata1, rdata;

    // entry fields from memory
    logic signed [XW-1:0]      m_x, m_y;
    logic [SW-1:0]             m_w, m_h;

    assign rdata = bank_reg ? rdata1 : rdata0;
    assign {m_x, m_y, m_w, m_h} = rdata;

    // geometry of the loaded entry
    logic signed [EW-1:0] rx1, ry1, rx2, ry2;
    logic                 covered, overlaps;
    logic [rre_pkg::PC_N-1:0] mask_new;

    assign rx1 = EW'(rx_reg);
    assign ry1 = EW'(ry_reg);
    assign rx2 = rx1 + EW'({1'b0, rw_reg});
    assign ry2 = ry1 + EW'({1'b0, rh_reg});

    assign covered  = (rx1 >= bx1_reg) && (rx2 <= bx2_reg) &&
                      (ry1 >= by1_reg) && (ry2 <= by2_reg);
    assign overlaps = (bx1_reg < rx2) && (rx1 < bx2_reg) &&
                      (by1_reg < ry2) && (ry1 < by2_reg);

    always_comb
    begin
        mask_new = '0;
        if (kind_reg == rre_pkg::CMD_ADD)
        begin
            mask_new[rre_pkg::PC_KEEP] = !covered;
        end
        else if (!overlaps)
        begin
            mask_new[rre_pkg::PC_KEEP] = 1'b1;
        end
        else
        begin
            mask_new[rre_pkg::PC_ABOVE] = by1_reg > ry1;
            mask_new[rre_pkg::PC_BELOW] = by2_reg < ry2;
            mask_new[rre_pkg::PC_LEFT]  = bx1_reg > rx1;
            mask_new[rre_pkg::PC_RIGHT] = bx2_reg < rx2;
        end
    end

    // lowest pending piece and its rectangle
    logic signed [EW-1:0] px, py, pw, ph;
    logic [rre_pkg::PC_N-1:0] mask_clr;

    always_comb
    begin
        px       = rx1;
        py       = ry1;
        pw       = EW'({1'b0, rw_reg});
        ph       = EW'({1'b0, rh_reg});
        mask_clr = mask_reg;
        if (mask_reg[rre_pkg::PC_KEEP])
        begin
            mask_clr[rre_pkg::PC_KEEP] = 1'b0;
        end
        else if (mask_reg[rre_pkg::PC_ABOVE])
        begin
            ph = cy1_reg - ry1;
            mask_clr[rre_pkg::PC_ABOVE] = 1'b0;
        end
        else if (mask_reg[rre_pkg::PC_BELOW])
        begin
            py = cy2_reg;
            ph = ry2_reg - cy2_reg;
            mask_clr[rre_pkg::PC_BELOW] = 1'b0;
        end
        else if (mask_reg[rre_pkg::PC_LEFT])
        begin
            py = cy1_reg;
            pw = cx1_reg - rx1;
            ph = cy2_reg - cy1_reg;
            mask_clr[rre_pkg::PC_LEFT] = 1'b0;
        end
        else
        begin
            px = cx2_reg;
            py = cy1_reg;
            pw = rx2_reg - cx2_reg;
            ph = cy2_reg - cy1_reg;
            mask_clr[rre_pkg::PC_RIGHT] = 1'b0;
        end
    end

    // write port to the inactive bank
    logic wr_req, full;

    assign full   = (wcnt_reg == CW'(CAPACITY));
    assign wr_req = (cmd.write_piece || cmd.append) && !full;
    assign we0    = wr_req && bank_reg;
    assign we1    = wr_req && !bank_reg;

    always_comb
    begin
        if (cmd.append)
            wdata = {bx1_reg[XW-1:0], by1_reg[XW-1:0], bw_reg, bh_reg};
        else
            wdata = {px[XW-1:0], py[XW-1:0], pw[SW-1:0], ph[SW-1:0]};
    end

    rre_ram #(.WIDTH(rre_pkg::ENTRY_W), .DEPTH(CAPACITY), .AW(AW)) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (wcnt_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata0)
    );

    rre_ram #(.WIDTH(rre_pkg::ENTRY_W), .DEPTH(CAPACITY), .AW(AW)) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (wcnt_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata1)
    );

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg   <= command;
            active_reg <= (command == rre_pkg::CMD_ADD || command == rre_pkg::CMD_SUB) &&
                          (size_w > 0) && (size_h > 0);
            bx1_reg    <= EW'(pos_x);
            by1_reg    <= EW'(pos_y);
            bx2_reg    <= EW'(pos_x) + EW'(size_w);
            by2_reg    <= EW'(pos_y) + EW'(size_h);
            bw_reg     <= size_w[SW-1:0];
            bh_reg     <= size_h[SW-1:0];
        end
    end

    // entry load and clipping
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rx_reg <= m_x;
            ry_reg <= m_y;
            rw_reg <= m_w;
            rh_reg <= m_h;
        end
        if (cmd.calc)
        begin
            rx2_reg  <= rx2;
            ry2_reg  <= ry2;
            cx1_reg  <= (bx1_reg > rx1) ? bx1_reg : rx1;
            cx2_reg  <= (bx2_reg < rx2) ? bx2_reg : rx2;
            cy1_reg  <= (by1_reg > ry1) ? by1_reg : ry1;
            cy2_reg  <= (by2_reg < ry2) ? by2_reg : ry2;
        end
    end

    // counters, bank select, overflow and piece mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            wcnt_reg  <= '0;
            bank_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            mask_reg  <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg  <= '0;
                wcnt_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            if (cmd.next_idx)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.calc)
            begin
                mask_reg <= mask_new;
            end
            if (cmd.write_piece)
            begin
                mask_reg <= mask_clr;
            end
            if (cmd.write_piece || cmd.append)
            begin
                if (full)
                    ovf_reg <= 1'b1;
                else
                    wcnt_reg <= wcnt_reg + 1'b1;
            end
            if (cmd.flip)
            begin
                bank_reg  <= !bank_reg;
                count_reg <= wcnt_reg;
            end
        end
    end

    // result register
    logic out_accept;
    assign out_accept = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if (cmd.ack || cmd.list_item)
        begin
            result_valid <= 1'b1;
        end
        else if (out_accept)
        begin
            result_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ack)
        begin
            rect_x     <= '0;
            rect_y     <= '0;
            rect_w     <= '0;
            rect_h     <= '0;
            rect_valid <= 1'b0;
            last_item  <= 1'b1;
            status     <= ovf_reg;
        end
        else if (cmd.list_item)
        begin
            rect_x     <= m_x;
            rect_y     <= m_y;
            rect_w     <= m_w;
            rect_h     <= m_h;
            rect_valid <= 1'b1;
            last_item  <= stat.idx_last;
            status     <= 1'b0;
        end
    end

    // status toward the sequencer
    assign stat.is_list    = (kind_reg == rre_pkg::CMD_LIST);
    assign stat.is_add     = (kind_reg == rre_pkg::CMD_ADD);
    assign stat.is_active  = active_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.idx_last   = ((idx_reg + 1'b1) == count_reg);
    assign stat.mask_empty = (mask_reg == '0);
    assign stat.out_accept = out_accept;

    `ASSERT_CLK(a_count_bound, count_reg <= CW'(CAPACITY), "table count above capacity")
    `ASSERT_CLK(a_wcnt_bound, wcnt_reg <= CW'(CAPACITY), "write count above capacity")
    `ASSERT_NEXT(a_full_ovf, (cmd.write_piece || cmd.append) && full, ovf_reg,
                 "dropped piece without overflow flag")
    `ASSERT_CLK(a_one_bank, !(we0 && we1), "both banks written")

endmodule

// ===== hw/rtl/rectangle_region_engine.sv =====
// top level of the rectangle region engine
// depends on rre_pkg, rre_ctrl and rre_dp
//
// Usage: a request on the command channel (command_valid / command_stall)
// carries command, pos_x, pos_y, size_w, size_h. Add and subtract give one
// acknowledge result with status; list gives one result per stored
// rectangle (last_item on the final one), or one empty result.
// Results leave on the result channel (result_valid / result_stall).
// Flow: one request at a time. For an add or subtract of a box with positive
// size the sequencer visits every stored entry through a ram with registered
// read, in the states fetch, load, calc and piece, and writes the kept slices
// from the piece state. A list fetches and loads each entry, then waits for
// each result to be taken. Reset clears the rectangle count, so the table
// starts empty; no clearing pass is needed. The table lives in two banks that
// swap after each add or subtract with positive size. While the receiver
// stalls, the result stays in its register and no new request is taken.
module rectangle_region_engine #(
    parameter int CAPACITY = rre_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                command_valid,
    output logic                                command_stall,
    input  logic [rre_pkg::CMD_W-1:0]           command,
    input  logic signed [rre_pkg::IN_W-1:0]     pos_x,
    input  logic signed [rre_pkg::IN_W-1:0]     pos_y,
    input  logic signed [rre_pkg::IN_W-1:0]     size_w,
    input  logic signed [rre_pkg::IN_W-1:0]     size_h,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [rre_pkg::COORD_W-1:0]  rect_x,
    output logic signed [rre_pkg::COORD_W-1:0]  rect_y,
    output logic [rre_pkg::SIZE_W-1:0]          rect_w,
    output logic [rre_pkg::SIZE_W-1:0]          rect_h,
    output logic                                rect_valid,
    output logic                                last_item,
    output logic                                status
);

    rre_pkg::rre_cmd_t  cmd;
    rre_pkg::rre_stat_t stat;

    // sequencer
    rre_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .command_valid (command_valid),
        .command_stall (command_stall),
        .stat          (stat),
        .cmd           (cmd)
    );

    // datapath
    rre_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .size_w       (size_w),
        .size_h       (size_h),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_w       (rect_w),
        .rect_h       (rect_h),
        .rect_valid   (rect_valid),
        .last_item    (last_item),
        .status       (status)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the rectangle region engine: random and directed requests,
// a software region table predicts every result; depends on rre_pkg and the rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = rre_pkg::CAPACITY_DEF;
    localparam logic [rre_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [rre_pkg::CMD_W-1:0] cmd;
        logic signed [15:0] x, y, w, h;
    } req_t;

    typedef struct {
        logic signed [16:0] x, y;
        logic [14:0] w, h;
        logic valid, last, st;
    } res_t;

    typedef struct {
        int x, y, w, h;
    } box_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic command_valid = 1'b0;
    logic command_stall;
    logic [rre_pkg::CMD_W-1:0] command = '0;
    logic signed [15:0] pos_x = '0, pos_y = '0, size_w = '0, size_h = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [16:0] rect_x, rect_y;
    logic [14:0] rect_w, rect_h;
    logic rect_valid, last_item, status;

    req_t pending_reqs[$];
    res_t expected_results[$];
    box_t region[$];
    int errors = 0;
    int results_seen = 0;
    int sent = 0;
    int hold_off = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit drain_pause = 0;
    bit long_hold = 0;

    rectangle_region_engine dut (.*);

    always #2 clk = ~clk;

    // predicted acknowledge or list results
    function automatic void push_res(int x, int y, int w, int h, bit v, bit l, bit s);
        res_t r;
        r.x = x[16:0]; r.y = y[16:0]; r.w = w[14:0]; r.h = h[14:0];
        r.valid = v; r.last = l; r.st = s;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic bit covers(box_t a, box_t b);
        return b.x >= a.x && b.x + b.w <= a.x + a.w &&
               b.y >= a.y && b.y + b.h <= a.y + a.h;
    endfunction

    function automatic bit overlaps(box_t a, box_t b);
        return b.x < a.x + a.w && a.x < b.x + b.w &&
               b.y < a.y + a.h && a.y < b.y + b.h;
    endfunction

    function automatic void keep_piece(ref box_t q[$], ref bit over,
                                       input int x, int y, int w, int h);
        box_t b;
        if (q.size() < CAP)
        begin
            b.x = x; b.y = y; b.w = w; b.h = h;
            q.insert(q.size(), b);
        end
        else
            over = 1;
    endfunction

    // update the region and queue what the request returns
    function automatic void predict_region(req_t r);
        box_t nb, q[$], o;
        bit over;
        int hx1, hx2, hy1, hy2;
        nb.x = r.x; nb.y = r.y; nb.w = r.w; nb.h = r.h;
        over = 0;
        if (r.cmd == rre_pkg::CMD_LIST)
        begin
            if (region.size() == 0)
                push_res(0, 0, 0, 0, 0, 1, 0);
            foreach (region[i])
                push_res(region[i].x, region[i].y, region[i].w, region[i].h, 1,
                         i == region.size() - 1, 0);
            return;
        end
        if ((r.cmd == rre_pkg::CMD_ADD || r.cmd == rre_pkg::CMD_SUB) && nb.w > 0 && nb.h > 0)
        begin
            if (r.cmd == rre_pkg::CMD_ADD)
            begin
                foreach (region[i])
                    if (!covers(nb, region[i]))
                        q.insert(q.size(), region[i]);
                if (q.size() < CAP)
                    q.insert(q.size(), nb);
                else
                    over = 1;
            end
            else
            begin
                foreach (region[i])
                begin
                    o = region[i];
                    if (!overlaps(o, nb))
                    begin
                        keep_piece(q, over, o.x, o.y, o.w, o.h);
                        continue;
                    end
                    hx1 = nb.x > o.x ? nb.x : o.x;
                    hx2 = nb.x + nb.w < o.x + o.w ? nb.x + nb.w : o.x + o.w;
                    hy1 = nb.y > o.y ? nb.y : o.y;
                    hy2 = nb.y + nb.h < o.y + o.h ? nb.y + nb.h : o.y + o.h;
                    if (o.y < hy1)
                        keep_piece(q, over, o.x, o.y, o.w, hy1 - o.y);
                    if (hy2 < o.y + o.h)
                        keep_piece(q, over, o.x, hy2, o.w, o.y + o.h - hy2);
                    if (o.x < hx1)
                        keep_piece(q, over, o.x, hy1, hx1 - o.x, hy2 - hy1);
                    if (hx2 < o.x + o.w)
                        keep_piece(q, over, hx2, hy1, o.x + o.w - hx2, hy2 - hy1);
                end
            end
            region = q;
        end
        push_res(0, 0, 0, 0, 0, 1, over);
    endfunction

    function automatic req_t mk(logic [1:0] c, int x, int y, int w, int h);
        req_t r;
        r.cmd = c; r.x = 16'(x); r.y = 16'(y); r.w = 16'(w); r.h = 16'(h);
        return r;
    endfunction

    // mostly small boxes near the origin, sometimes full-range values
    function automatic req_t rand_req();
        req_t r;
        int k;
        k = $urandom_range(0, 99);
        r.cmd = k < 45 ? rre_pkg::CMD_ADD : k < 80 ? rre_pkg::CMD_SUB :
                k < 96 ? rre_pkg::CMD_LIST : CMD_NONE;
        if ($urandom_range(0, 9) == 0)
        begin
            r.x = 16'($urandom); r.y = 16'($urandom);
            r.w = 16'($urandom); r.h = 16'($urandom);
        end
        else
        begin
            r.x = 16'(int'($urandom_range(0, 60)) - 30);
            r.y = 16'(int'($urandom_range(0, 60)) - 30);
            r.w = 16'(int'($urandom_range(0, 40)) - 2);
            r.h = 16'(int'($urandom_range(0, 40)) - 2);
        end
        return r;
    endfunction

    // request driver: bursts with gaps, optional pause until drained
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (command_valid && !command_stall)
                sent <= sent + 1;
            if (!command_valid || !command_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    command_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 &&
                         !(drain_pause && expected_results.size() != 0))
                begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    predict_region(r);
                    command_valid <= 1'b1;
                    command <= r.cmd;
                    pos_x <= r.x; pos_y <= r.y; size_w <= r.w; size_h <= r.h;
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= $urandom_range(0, 6);
                    end
                end
                else
                    command_valid <= 1'b0;
            end
        end
    end

    // result stall pattern, with one long hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            result_stall <= 1'b1;
        end
        else if (long_hold)
        begin
            hold_off <= 300;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 7) < 3) && results_seen % 64 > 20;
    end

    // result monitor and comparison
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            res_t e;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result x=%0d y=%0d", $time, rect_x, rect_y);
                errors <= errors + 1;
            end
            else
            begin
                e = expected_results.pop_front();
                if ({rect_x, rect_y, rect_w, rect_h, rect_valid, last_item, status} !==
                    {e.x, e.y, e.w, e.h, e.valid, e.last, e.st})
                begin
                    $display("%0t mismatch expected x=%0d y=%0d w=%0d h=%0d v=%0d l=%0d s=%0d",
                             $time, e.x, e.y, e.w, e.h, e.valid, e.last, e.st);
                    $display("%0t          actual   x=%0d y=%0d w=%0d h=%0d v=%0d l=%0d s=%0d",
                             $time, rect_x, rect_y, rect_w, rect_h, rect_valid,
                             last_item, status);
                    errors <= errors + 1;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("rectangle_region_engine regression: fail");
        $finish;
    end

    initial
    begin
        // directed: extremes, degenerate boxes, empty list, unused code
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_LIST, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_ADD, 0, 0, 0, 5));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_SUB, 0, 0, 5, -32768));
        pending_reqs.insert(pending_reqs.size(),
                            mk(rre_pkg::CMD_ADD, -32768, -32768, 32767, 32767));
        pending_reqs.insert(pending_reqs.size(),
                            mk(rre_pkg::CMD_ADD, 32767, 32767, 32767, 32767));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_LIST, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_SUB, -100, -100, 200, 200));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_LIST, -1, -1, -1, -1));
        pending_reqs.insert(pending_reqs.size(), mk(CMD_NONE, -1, -1, -1, -1));
        pending_reqs.insert(pending_reqs.size(),
                            mk(rre_pkg::CMD_ADD, -32768, -32768, 32767, 32767));
        pending_reqs.insert(pending_reqs.size(),
                            mk(rre_pkg::CMD_SUB, -32768, -32768, 32767, 32767));
        for (int i = 0; i < 5; i++)
            pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_ADD, i * 20, 0, 10, 10));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_SUB, -5, 3, 200, 4));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_ADD, 200, 200, 10, 10));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_LIST, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_SUB, 3, 3, 2, 2));
        pending_reqs.insert(pending_reqs.size(), mk(rre_pkg::CMD_LIST, 0, 0, 0, 0));
        pending_reqs.insert(pending_reqs.size(),
                            mk(rre_pkg::CMD_ADD, -1000, -1000, 2000, 2000));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 250; i++)
            pending_reqs.insert(pending_reqs.size(), rand_req());
        wait (sent > 80);
        long_hold <= 1'b1;
        @(posedge clk);
        long_hold <= 1'b0;
        wait (sent > 160);
        drain_pause <= 1'b1;
        wait (expected_results.size() == 0);
        repeat (10) @(posedge clk);
        drain_pause <= 1'b0;
        wait (pending_reqs.size() == 0 && !command_valid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d requests and %0d results", sent, results_seen);
        if (errors == 0)
            $display("rectangle_region_engine regression: pass");
        else
            $display("rectangle_region_engine regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rre_pkg.sv
hw/rtl/rre_ram.sv
hw/rtl/rre_ctrl.sv
hw/rtl/rre_dp.sv
hw/rtl/rectangle_region_engine.sv
tb/sv/tb_top.sv
